>>> hw/rtl/pidq31_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq31_pkg
// Types and constants shared by the Q31 PID controller modules.
// ----------------------------------------------------------------------------
package pidq31_pkg;

  localparam int unsigned QW = 32;

  localparam logic signed [31:0] Q31_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q31_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_INT_LO  = 3'd3,
    REG_INT_HI  = 3'd4,
    REG_OUT_LO  = 3'd5,
    REG_OUT_HI  = 3'd6,
    REG_ALPHA   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MS_KP_E,
    MS_E_DT,
    MS_ALPHA_DIFF,
    MS_KD_FD,
    MS_KI_I
  } mul_sel_e;

  // datapath micro-ops issued by the controller
  typedef enum logic [3:0] {
    DO_NONE,
    DO_LOAD,
    DO_RESET,
    DO_MUL,
    DO_INT_UPD,
    DO_DIV1_START,
    DO_DIV_STEP,
    DO_FILT,
    DO_SUM,
    DO_DIV2_START,
    DO_INT_BACK,
    DO_COMMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_P,
    ST_EDT,
    ST_IUPD,
    ST_DIV1,
    ST_DIV1_RUN,
    ST_ALPHA,
    ST_FILT,
    ST_KD,
    ST_KI,
    ST_SUM,
    ST_DIV2_RUN,
    ST_COMMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_reset;
    logic reject;
    logic div_done;
    logic need_back;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return Q31_MAX;
    if (v < -35'sd2147483648) return Q31_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

>>> hw/rtl/pidq31_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq31_ctrl
// Sequencer for one PID item: issues datapath ops, handles the handshake.
// ----------------------------------------------------------------------------
module pidq31_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pidq31_pkg::dp_stat_t stat_i,
  output pidq31_pkg::dp_cmd_t  cmd_o
);

  pidq31_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidq31_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidq31_pkg::ST_IDLE:  if (in_valid_i) state_d = pidq31_pkg::ST_LOAD;
      pidq31_pkg::ST_LOAD: begin
        if (stat_i.is_reset || stat_i.reject) state_d = pidq31_pkg::ST_OUT;
        else state_d = pidq31_pkg::ST_P;
      end
      pidq31_pkg::ST_P:     state_d = pidq31_pkg::ST_EDT;
      pidq31_pkg::ST_EDT:   state_d = pidq31_pkg::ST_IUPD;
      pidq31_pkg::ST_IUPD:  state_d = pidq31_pkg::ST_DIV1;
      pidq31_pkg::ST_DIV1:  state_d = pidq31_pkg::ST_DIV1_RUN;
      pidq31_pkg::ST_DIV1_RUN: if (stat_i.div_done) state_d = pidq31_pkg::ST_ALPHA;
      pidq31_pkg::ST_ALPHA: state_d = pidq31_pkg::ST_FILT;
      pidq31_pkg::ST_FILT:  state_d = pidq31_pkg::ST_KD;
      pidq31_pkg::ST_KD:    state_d = pidq31_pkg::ST_KI;
      pidq31_pkg::ST_KI:    state_d = pidq31_pkg::ST_SUM;
      pidq31_pkg::ST_SUM:   state_d = pidq31_pkg::ST_COMMIT;
      pidq31_pkg::ST_COMMIT: begin
        if (stat_i.need_back) state_d = pidq31_pkg::ST_DIV2_RUN;
        else state_d = pidq31_pkg::ST_OUT;
      end
      pidq31_pkg::ST_DIV2_RUN: if (stat_i.div_done) state_d = pidq31_pkg::ST_OUT;
      pidq31_pkg::ST_OUT:   if (out_ready_i) state_d = pidq31_pkg::ST_IDLE;
      default:              state_d = pidq31_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = pidq31_pkg::DO_NONE;
    cmd_o.msel  = pidq31_pkg::MS_KP_E;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      pidq31_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = pidq31_pkg::DO_LOAD;
      end
      pidq31_pkg::ST_LOAD: begin
        if (stat_i.is_reset) cmd_o.op = pidq31_pkg::DO_RESET;
        else if (!stat_i.reject) begin
          cmd_o.op = pidq31_pkg::DO_MUL;
          cmd_o.msel = pidq31_pkg::MS_KP_E;
        end
      end
      pidq31_pkg::ST_P: begin
        cmd_o.op = pidq31_pkg::DO_MUL;
        cmd_o.msel = pidq31_pkg::MS_E_DT;
      end
      pidq31_pkg::ST_EDT:  cmd_o.op = pidq31_pkg::DO_INT_UPD;
      pidq31_pkg::ST_IUPD: cmd_o.op = pidq31_pkg::DO_DIV1_START;
      pidq31_pkg::ST_DIV1, pidq31_pkg::ST_DIV1_RUN, pidq31_pkg::ST_DIV2_RUN:
        cmd_o.op = pidq31_pkg::DO_DIV_STEP;
      pidq31_pkg::ST_ALPHA: begin
        cmd_o.op = pidq31_pkg::DO_MUL;
        cmd_o.msel = pidq31_pkg::MS_ALPHA_DIFF;
      end
      pidq31_pkg::ST_FILT: cmd_o.op = pidq31_pkg::DO_FILT;
      pidq31_pkg::ST_KD: begin
        cmd_o.op = pidq31_pkg::DO_MUL;
        cmd_o.msel = pidq31_pkg::MS_KD_FD;
      end
      pidq31_pkg::ST_KI: begin
        cmd_o.op = pidq31_pkg::DO_MUL;
        cmd_o.msel = pidq31_pkg::MS_KI_I;
      end
      pidq31_pkg::ST_SUM:    cmd_o.op = pidq31_pkg::DO_SUM;
      pidq31_pkg::ST_COMMIT: begin
        if (stat_i.need_back) cmd_o.op = pidq31_pkg::DO_DIV2_START;
        else cmd_o.op = pidq31_pkg::DO_COMMIT;
      end
      pidq31_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
    // back-calc finishes into the integrator when the second divide completes
    if (state_q == pidq31_pkg::ST_DIV2_RUN && stat_i.div_done)
      cmd_o.op = pidq31_pkg::DO_INT_BACK;
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pidq31_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("input accepted while busy");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before taken");
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == pidq31_pkg::ST_LOAD))
    else $error("accepted item not loaded");
`endif

endmodule

>>> hw/rtl/pidq31_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq31_dp
// PID datapath: shared Q31 multiplier, radix-2 divider, state and registers.
// ----------------------------------------------------------------------------
module pidq31_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_op_i,
  input  logic signed [31:0]   in_err_i,
  input  logic signed [31:0]   in_dt_i,
  input  logic signed [31:0]   in_preset_i,
  input  pidq31_pkg::dp_cmd_t  cmd_i,
  output pidq31_pkg::dp_stat_t stat_o,
  output logic signed [31:0]   ctl_out_o,
  output logic                 rejected_o,
  output logic                 limited_o
);

  logic signed [31:0] kp_q, ki_q, kd_q, ilo_q, ihi_q, olo_q, ohi_q, alpha_q;
  logic signed [31:0] integ_q, integ_d, perr_q, fd_q, lastout_q;
  logic signed [31:0] err_q, dt_q, p_q, dterm_q, mres_q;
  logic signed [31:0] draw_q, out_q;
  logic               op_q, rej_q, lim_q;
  logic               back_q;

  // divider
  logic [30:0]        dq_q;
  logic [32:0]        drem_q;
  logic [31:0]        dden_q;
  logic [5:0]         dcnt_q;
  logic               dbusy_q, dneg_q;
  logic signed [31:0] dres_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      ilo_q   <= pidq31_pkg::Q31_MIN;
      ihi_q   <= pidq31_pkg::Q31_MAX;
      olo_q   <= pidq31_pkg::Q31_MIN;
      ohi_q   <= pidq31_pkg::Q31_MAX;
      alpha_q <= pidq31_pkg::Q31_MAX;
    end else if (cfg_we_i) begin
      unique case (pidq31_pkg::reg_idx_e'(cfg_idx_i))
        pidq31_pkg::REG_KP:     kp_q    <= cfg_data_i;
        pidq31_pkg::REG_KI:     ki_q    <= cfg_data_i;
        pidq31_pkg::REG_KD:     kd_q    <= cfg_data_i;
        pidq31_pkg::REG_INT_LO: ilo_q   <= cfg_data_i;
        pidq31_pkg::REG_INT_HI: ihi_q   <= cfg_data_i;
        pidq31_pkg::REG_OUT_LO: olo_q   <= cfg_data_i;
        pidq31_pkg::REG_OUT_HI: ohi_q   <= cfg_data_i;
        pidq31_pkg::REG_ALPHA:  alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // multiplier: floor((a*b)>>31), saturated
  logic signed [31:0] ma, mb, alpha_c;
  logic signed [63:0] mprod;
  logic signed [32:0] mshift;
  logic signed [31:0] mres;
  always_comb begin
    alpha_c = alpha_q[31] ? 32'sd0 : alpha_q;
    ma = kp_q;
    mb = err_q;
    case (cmd_i.msel)
      pidq31_pkg::MS_KP_E:       begin ma = kp_q;    mb = err_q;  end
      pidq31_pkg::MS_E_DT:       begin ma = err_q;   mb = dt_q;   end
      pidq31_pkg::MS_ALPHA_DIFF: begin ma = alpha_c; mb = pidq31_pkg::sat32(
                                   {{3{draw_q[31]}}, draw_q} - {{3{fd_q[31]}}, fd_q}); end
      pidq31_pkg::MS_KD_FD:      begin ma = kd_q;    mb = fd_q;   end
      pidq31_pkg::MS_KI_I:       begin ma = ki_q;    mb = integ_q; end
      default: ;
    endcase
    mprod  = ma * mb;
    mshift = mprod[63:31];
    mres   = pidq31_pkg::sat32({{2{mshift[32]}}, mshift});
  end

  // sum and clamp
  logic signed [34:0] sum_w;
  logic signed [31:0] unsat_w, clamped_w;
  always_comb begin
    sum_w = {{3{p_q[31]}}, p_q} + {{3{mres_q[31]}}, mres_q}
          + {{3{dterm_q[31]}}, dterm_q};
    unsat_w = pidq31_pkg::sat32(sum_w);
    clamped_w = pidq31_pkg::clamp32(unsat_w, olo_q, ohi_q);
  end

  // divider start operands
  logic signed [34:0] dnum_w;
  logic signed [31:0] dden_w;
  logic [33:0]        nmag_w;
  logic [31:0]        dmag_w;
  always_comb begin
    if (cmd_i.op == pidq31_pkg::DO_DIV2_START) begin
      dnum_w = {{3{out_q[31]}}, out_q} - {{3{p_q[31]}}, p_q}
             - {{3{dterm_q[31]}}, dterm_q};
      dden_w = ki_q;
    end else begin
      dnum_w = {{3{err_q[31]}}, err_q} - {{3{perr_q[31]}}, perr_q};
      dden_w = dt_q;
    end
    nmag_w = dnum_w[34] ? 34'(-dnum_w) : dnum_w[33:0];
    dmag_w = dden_w[31] ? 32'(-dden_w) : dden_w;
  end

  logic [32:0] dtrial;
  assign dtrial = {drem_q[31:0], 1'b0} - {1'b0, dden_q};

  logic signed [31:0] dsigned;
  assign dsigned = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == pidq31_pkg::DO_DIV1_START ||
                 cmd_i.op == pidq31_pkg::DO_DIV2_START) begin
      dneg_q <= dnum_w[34] != dden_w[31];
      dden_q <= dmag_w;
      drem_q <= {1'b0, nmag_w[31:0]};
      dq_q   <= '0;
      dcnt_q <= 6'd31;
      if (dden_w == '0) begin
        dres_q  <= '0;
        dbusy_q <= 1'b0;
      end else if (nmag_w >= {2'b00, dmag_w}) begin
        dres_q  <= (dnum_w[34] != dden_w[31]) ? pidq31_pkg::Q31_MIN : pidq31_pkg::Q31_MAX;
        dbusy_q <= 1'b0;
      end else begin
        dbusy_q <= 1'b1;
      end
    end else if (dbusy_q) begin
      if (!dtrial[32]) begin
        drem_q <= dtrial;
        dq_q   <= {dq_q[29:0], 1'b1};
      end else begin
        drem_q <= {drem_q[31:0], 1'b0};
        dq_q   <= {dq_q[29:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 6'd1;
      if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
    end
  end

  logic div_done_w;
  assign div_done_w = !dbusy_q;
  logic signed [31:0] div_res_w;
  assign div_res_w = (dcnt_q == 6'd0) ? dsigned : dres_q;

  // integrator update after e*dt product
  always_comb begin
    integ_d = pidq31_pkg::clamp32(pidq31_pkg::sat32(
      {{3{integ_q[31]}}, integ_q} + {{3{mres_q[31]}}, mres_q}), ilo_q, ihi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      perr_q    <= '0;
      fd_q      <= '0;
      lastout_q <= '0;
      op_q      <= 1'b0;
      rej_q     <= 1'b0;
      lim_q     <= 1'b0;
      back_q    <= 1'b0;
      out_q     <= '0;
    end else begin
      case (cmd_i.op)
        pidq31_pkg::DO_LOAD: begin
          op_q  <= in_op_i;
          err_q <= in_err_i;
          dt_q  <= in_dt_i;
          rej_q <= !in_op_i && (in_dt_i <= 32'sd0);
          lim_q <= 1'b0;
          out_q <= in_op_i ? in_preset_i : 32'sd0;
        end
        pidq31_pkg::DO_RESET: begin
          integ_q   <= '0;
          perr_q    <= '0;
          fd_q      <= '0;
          lastout_q <= out_q;
        end
        pidq31_pkg::DO_MUL: begin
          mres_q <= mres;
          if (cmd_i.msel == pidq31_pkg::MS_KP_E) p_q <= mres;
          if (cmd_i.msel == pidq31_pkg::MS_KD_FD) dterm_q <= mres;
        end
        pidq31_pkg::DO_INT_UPD: integ_q <= integ_d;
        pidq31_pkg::DO_DIV_STEP: if (div_done_w) draw_q <= div_res_w;
        pidq31_pkg::DO_FILT: begin
          fd_q   <= pidq31_pkg::sat32({{3{fd_q[31]}}, fd_q} + {{3{mres_q[31]}}, mres_q});
          perr_q <= err_q;
        end
        pidq31_pkg::DO_SUM: begin
          out_q  <= clamped_w;
          lim_q  <= clamped_w != unsat_w;
          back_q <= (clamped_w != unsat_w) && (ki_q != '0);
        end
        pidq31_pkg::DO_COMMIT: lastout_q <= out_q;
        pidq31_pkg::DO_INT_BACK: begin
          integ_q   <= pidq31_pkg::clamp32(div_res_w, ilo_q, ihi_q);
          lastout_q <= out_q;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.is_reset  = op_q;
  assign stat_o.reject    = rej_q;
  assign stat_o.div_done  = div_done_w;
  assign stat_o.need_back = back_q;
  assign ctl_out_o  = out_q;
  assign rejected_o = rej_q;
  assign limited_o  = lim_q;

`ifndef ASSERT_OFF
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy_q |-> (dcnt_q != 6'd0))
    else $error("divider busy with zero count");
  a_rej_nolim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q |-> !lim_q)
    else $error("rejected step flagged as limited");
  a_back_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pidq31_pkg::DO_DIV2_START) |-> (lim_q && ki_q != '0))
    else $error("back-calculation without limit");
`endif

endmodule

>>> hw/rtl/pid_controller_q31_filtered_derivative.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_q31_filtered_derivative
// Q31 PID controller with filtered derivative and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Sequence: a reset op or a rejected step goes from accept straight to the result;
//   a control step runs one divide, and a second when back-calculation runs; a
//   divide by zero or with a saturated quotient skips its quotient-bit steps.
// Flow: one item at a time; the next is taken in the cycle after the result is taken.
// The radix-2 divider yields one quotient bit per cycle.
// Reset (rst_ni low, async): gains cleared, limits and alpha to full range,
//   controller state to zero.
module pid_controller_q31_filtered_derivative (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // error[31:0], time_step[63:32], preset_output[95:64]
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // control_out
  output logic [1:0]  m_axis_tuser   // step_rejected[0], output_limited[1]
);

  pidq31_pkg::dp_cmd_t  cmd;
  pidq31_pkg::dp_stat_t stat;
  logic signed [31:0]   ctl_out;
  logic                 rejected, limited;

  assign cfg_ready_o = 1'b1;

  pidq31_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pidq31_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (s_axis_tuser),
    .in_err_i    (s_axis_tdata[31:0]),
    .in_dt_i     (s_axis_tdata[63:32]),
    .in_preset_i (s_axis_tdata[95:64]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .ctl_out_o   (ctl_out),
    .rejected_o  (rejected),
    .limited_o   (limited)
  );

  assign m_axis_tdata = ctl_out;
  assign m_axis_tuser = {limited, rejected};

endmodule
